>>> hdl/rpnh_pkg.sv
// ---------------------------------------------------------------------------
// rpnh_pkg: shared widths and codes for the ray polygon nearest hit block
// Field widths of the item, result and configuration channels and the
// configuration register indexes.
// ---------------------------------------------------------------------------
package rpnh_pkg;

  localparam int COORD_W          = 32;
  localparam int VIDX_W           = 4;
  localparam int CNT_W            = 5;
  localparam int TEX_W            = 31;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_VERTICES_DEF = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_VERTEX_COUNT = 2'd0;
  localparam cfg_idx_t REG_ORIGIN_X     = 2'd1;
  localparam cfg_idx_t REG_ORIGIN_Y     = 2'd2;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd2;

endpackage

>>> hdl/rpnh_if.sv
// ---------------------------------------------------------------------------
// rpnh_if: channel interfaces of the ray polygon nearest hit block
// Item channel, result channel and configuration write channel, each with
// valid, ready and payload.
// ---------------------------------------------------------------------------
interface rpnh_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [rpnh_pkg::VIDX_W-1:0]         vertex_index;
  logic signed [rpnh_pkg::COORD_W-1:0] vertex_x;
  logic signed [rpnh_pkg::COORD_W-1:0] vertex_y;
  logic signed [rpnh_pkg::COORD_W-1:0] ray_start_x;
  logic signed [rpnh_pkg::COORD_W-1:0] ray_start_y;
  logic signed [rpnh_pkg::COORD_W-1:0] ray_end_x;
  logic signed [rpnh_pkg::COORD_W-1:0] ray_end_y;
  logic signed [rpnh_pkg::COORD_W-1:0] best_x;
  logic signed [rpnh_pkg::COORD_W-1:0] best_y;

  modport source (output valid, action, vertex_index, vertex_x, vertex_y, ray_start_x,
                  ray_start_y, ray_end_x, ray_end_y, best_x, best_y, input ready);
  modport sink (input valid, action, vertex_index, vertex_x, vertex_y, ray_start_x,
                ray_start_y, ray_end_x, ray_end_y, best_x, best_y, output ready);
endinterface

interface rpnh_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [rpnh_pkg::COORD_W-1:0] hit_x;
  logic signed [rpnh_pkg::COORD_W-1:0] hit_y;
  logic signed [rpnh_pkg::COORD_W-1:0] wall_start_x;
  logic signed [rpnh_pkg::COORD_W-1:0] wall_start_y;
  logic signed [rpnh_pkg::COORD_W-1:0] wall_end_x;
  logic signed [rpnh_pkg::COORD_W-1:0] wall_end_y;
  logic [rpnh_pkg::TEX_W-1:0]          tex_offset;

  modport source (output valid, hit, hit_x, hit_y, wall_start_x, wall_start_y, wall_end_x,
                  wall_end_y, tex_offset, input ready);
  modport sink (input valid, hit, hit_x, hit_y, wall_start_x, wall_start_y, wall_end_x,
                wall_end_y, tex_offset, output ready);
endinterface

interface rpnh_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rpnh_pkg::CFG_IDX_W-1:0] index;
  logic [rpnh_pkg::COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/rpnh_vstore.sv
// ---------------------------------------------------------------------------
// rpnh_vstore: polygon vertex store
// One write port and one registered read port for vertex x and y.
// ---------------------------------------------------------------------------
module rpnh_vstore #(
  parameter int DEPTH = rpnh_pkg::MAX_VERTICES_DEF,
  parameter int AW    = $clog2(rpnh_pkg::MAX_VERTICES_DEF)
) (
  input  logic                         clk,
  input  logic                         wen,
  input  logic [AW-1:0]                waddr,
  input  logic [rpnh_pkg::COORD_W-1:0] wx,
  input  logic [rpnh_pkg::COORD_W-1:0] wy,
  input  logic [AW-1:0]                raddr,
  output logic [rpnh_pkg::COORD_W-1:0] rx,
  output logic [rpnh_pkg::COORD_W-1:0] ry
);

  logic [rpnh_pkg::COORD_W-1:0] mem_x [DEPTH];
  logic [rpnh_pkg::COORD_W-1:0] mem_y [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
  end

endmodule

>>> hdl/ray_polygon_nearest_hit.sv
// ---------------------------------------------------------------------------
// ray_polygon_nearest_hit: nearest proper crossing of a ray with a polygon
// Loads polygon vertices into a store and, per cast beat, walks the edges
// with one shared 34x34 multiplier, a restoring divider and a square root.
// ---------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  cfg      in   valid / ready    index, data
//  item     in   valid / ready    action, vertex_index, vertex, ray, best point
//  result   out  valid / ready    hit, hit point, wall ends, tex_offset
//
//  a cast beat walks each edge with product pairs on the shared multiplier,
//  runs two divisions per edge that crosses and a square root when a hit is
//  found; with fewer than two vertices it skips the edge walk.
//  rst is synchronous and clears control state; the vertex store is not cleared.
//  item.ready is high only while idle; a finished result waits in the output
//  register and a new beat may be taken meanwhile.
// ---------------------------------------------------------------------------
module ray_polygon_nearest_hit #(
  parameter int MAX_VERTICES = rpnh_pkg::MAX_VERTICES_DEF
) (
  input  logic  clk,
  input  logic  rst,
  rpnh_cfg_if.sink   cfg,
  rpnh_in_if.sink    item,
  rpnh_out_if.source result
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = rpnh_pkg::CNT_W;

  typedef logic signed [33:0] op_t;
  typedef logic signed [67:0] prod_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_PAIR = 11'b00000000010,
    S_RDA  = 11'b00000000100,
    S_LATA = 11'b00000001000,
    S_RDB  = 11'b00000010000,
    S_LATB = 11'b00000100000,
    S_DIV  = 11'b00001000000,
    S_NEXT = 11'b00010000000,
    S_FIN  = 11'b00100000000,
    S_SQRT = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  typedef enum logic [3:0] {
    J_BEST, J_C1, J_C2, J_C3, J_C4, J_NX, J_NY, J_CD, J_WD
  } job_t;

  function automatic op_t dif(input logic [31:0] a, input logic [31:0] b);
    return op_t'($signed(a)) - op_t'($signed(b));
  endfunction

  function automatic logic opposite(input prod_t a, input prod_t b);
    return (a != '0) && (b != '0) && (a[67] != b[67]);
  endfunction

  state_t state;
  job_t   job;
  logic [1:0] ph;

  logic [CW-1:0] vcount;
  logic [31:0]   origin_x, origin_y;

  logic [31:0] r0x, r0y, r1x, r1y, bx, by;
  logic [31:0] w0x, w0y, w1x, w1y, wsx, wsy, wex, wey;
  logic [31:0] candx, candy;
  logic [67:0] bestd;
  prod_t       ca;
  logic [65:0] aval;
  logic [66:0] sval;
  logic [32:0] qx, q;
  logic [99:0] rem, dsh;
  logic [5:0]  it;
  logic        div_y, found;
  logic [CW-1:0] nuse, kcnt;
  logic [67:0] sq_op, sq_res, sq_one;
  logic [rpnh_pkg::TEX_W-1:0] tex;

  prod_t p, acc;
  op_t   ma, mb;
  op_t   a1, b1, a2, b2;

  // vertex store
  logic          st_wen;
  logic [AW-1:0] st_raddr;
  logic [31:0]   st_rx, st_ry;
  logic [31:0]   wvx, wvy;

  assign st_wen   = item.valid && item.ready && !item.action
                    && (int'(item.vertex_index) < MAX_VERTICES);
  assign st_raddr = (state == S_RDA) ? AW'(nuse - CW'(1)) : AW'(kcnt);
  assign wvx      = origin_x + st_rx;
  assign wvy      = origin_y + st_ry;

  rpnh_vstore #(.DEPTH(MAX_VERTICES), .AW(AW)) u_vstore (
    .clk   (clk),
    .wen   (st_wen),
    .waddr (AW'(item.vertex_index)),
    .wx    (item.vertex_x),
    .wy    (item.vertex_y),
    .raddr (st_raddr),
    .rx    (st_rx),
    .ry    (st_ry)
  );

  // ray direction and magnitudes
  op_t d1x, d1y, mx, my;
  assign d1x = dif(r1x, r0x);
  assign d1y = dif(r1y, r0y);
  assign mx  = d1x[33] ? -d1x : d1x;
  assign my  = d1y[33] ? -d1y : d1y;

  always_comb begin
    a1 = '0;
    b1 = '0;
    a2 = '0;
    b2 = '0;
    case (job)
      J_BEST: begin
        a1 = dif(bx, r0x); b1 = a1; a2 = dif(by, r0y); b2 = a2;
      end
      J_C1: begin
        a1 = d1x; b1 = dif(w0y, r0y); a2 = d1y; b2 = dif(w0x, r0x);
      end
      J_C2: begin
        a1 = d1x; b1 = dif(w1y, r0y); a2 = d1y; b2 = dif(w1x, r0x);
      end
      J_C3: begin
        a1 = dif(w1x, w0x); b1 = dif(r0y, w0y); a2 = dif(w1y, w0y); b2 = dif(r0x, w0x);
      end
      J_C4: begin
        a1 = dif(w1x, w0x); b1 = dif(r1y, w0y); a2 = dif(w1y, w0y); b2 = dif(r1x, w0x);
      end
      J_NX: begin
        a1 = op_t'({1'b0, aval[32:0]}); b1 = mx; a2 = op_t'({1'b0, aval[65:33]}); b2 = mx;
      end
      J_NY: begin
        a1 = op_t'({1'b0, aval[32:0]}); b1 = my; a2 = op_t'({1'b0, aval[65:33]}); b2 = my;
      end
      J_CD: begin
        a1 = op_t'({1'b0, qx}); b1 = a1; a2 = op_t'({1'b0, q}); b2 = a2;
      end
      J_WD: begin
        a1 = dif(wex, bx); b1 = a1; a2 = dif(wey, by); b2 = a2;
      end
      default: begin
        a1 = '0;
      end
    endcase
    ma = ph[0] ? a2 : a1;
    mb = ph[0] ? b2 : b1;
  end

  // shared multiplier, registered product
  always_ff @(posedge clk) begin
    p   <= ma * mb;
    acc <= p;
  end

  prod_t       res, abs_ca, abs_res;
  logic [99:0] res_n;
  assign res     = (job == J_BEST || job == J_CD || job == J_WD) ? acc + p : acc - p;
  assign res_n   = {32'b0, acc} + ({32'b0, p} << 33);
  assign abs_ca  = ca[67] ? -ca : ca;
  assign abs_res = res[67] ? -res : res;

  // divider step
  logic        div_ge;
  logic [32:0] q_next;
  logic [31:0] cand_next;
  assign div_ge    = rem >= dsh;
  assign q_next    = {q[31:0], div_ge};
  assign cand_next = div_y ? (d1y[33] ? r0y - q_next[31:0] : r0y + q_next[31:0])
                           : (d1x[33] ? r0x - q_next[31:0] : r0x + q_next[31:0]);

  // square root step
  logic [67:0] sq_t, sq_res_next;
  logic        sq_ge;
  assign sq_t        = sq_res + sq_one;
  assign sq_ge       = sq_op >= sq_t;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + sq_one : sq_res >> 1;

  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount   <= rpnh_pkg::VERTEX_COUNT_RST;
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rpnh_pkg::REG_VERTEX_COUNT: vcount   <= cfg.data[CW-1:0];
        rpnh_pkg::REG_ORIGIN_X:     origin_x <= cfg.data;
        rpnh_pkg::REG_ORIGIN_Y:     origin_y <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      job          <= J_BEST;
      ph           <= '0;
      result.valid <= 1'b0;
    end else begin
      // in S_OUT the new beat takes the register instead
      if (result.valid && result.ready && state != S_OUT) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item.valid && item.action) begin
            r0x   <= item.ray_start_x;
            r0y   <= item.ray_start_y;
            r1x   <= item.ray_end_x;
            r1y   <= item.ray_end_y;
            bx    <= item.best_x;
            by    <= item.best_y;
            found <= 1'b0;
            wsx   <= '0;
            wsy   <= '0;
            wex   <= '0;
            wey   <= '0;
            nuse  <= (int'(vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : vcount;
            kcnt  <= '0;
            job   <= J_BEST;
            ph    <= '0;
            state <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (ph != 2'd2) begin
            ph <= ph + 2'd1;
          end else begin
            ph <= '0;
            case (job)
              J_BEST: begin
                bestd <= res;
                state <= (nuse < CW'(2)) ? S_FIN : S_RDA;
              end
              J_C1: begin
                ca  <= res;
                job <= J_C2;
              end
              J_C2: begin
                if (opposite(ca, res)) begin
                  job <= J_C3;
                end else begin
                  state <= S_NEXT;
                end
              end
              J_C3: begin
                ca  <= res;
                job <= J_C4;
              end
              J_C4: begin
                if (opposite(ca, res)) begin
                  aval <= abs_ca[65:0];
                  sval <= {1'b0, abs_ca[65:0]} + {1'b0, abs_res[65:0]};
                  job  <= J_NX;
                end else begin
                  state <= S_NEXT;
                end
              end
              J_NX, J_NY: begin
                rem   <= res_n;
                dsh   <= {1'b0, sval, 32'b0};
                q     <= '0;
                it    <= 6'd32;
                div_y <= (job == J_NY);
                state <= S_DIV;
              end
              J_CD: begin
                if (res < bestd) begin
                  found <= 1'b1;
                  bestd <= res;
                  bx    <= candx;
                  by    <= candy;
                  wsx   <= w0x;
                  wsy   <= w0y;
                  wex   <= w1x;
                  wey   <= w1y;
                end
                state <= S_NEXT;
              end
              J_WD: begin
                sq_op  <= res;
                sq_res <= '0;
                sq_one <= 68'd1 << 66;
                it     <= 6'd33;
                state  <= S_SQRT;
              end
              default: state <= S_NEXT;
            endcase
          end
        end
        S_RDA: state <= S_LATA;
        S_LATA: begin
          w1x   <= wvx;
          w1y   <= wvy;
          state <= S_RDB;
        end
        S_RDB: begin
          w0x   <= w1x;
          w0y   <= w1y;
          state <= S_LATB;
        end
        S_LATB: begin
          w1x   <= wvx;
          w1y   <= wvy;
          job   <= J_C1;
          state <= S_PAIR;
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - dsh;
          end
          dsh <= dsh >> 1;
          q   <= q_next;
          it  <= it - 6'd1;
          if (it == '0) begin
            if (div_y) begin
              candy <= cand_next;
              job   <= J_CD;
            end else begin
              candx <= cand_next;
              qx    <= q_next;
              job   <= J_NY;
            end
            state <= S_PAIR;
          end
        end
        S_NEXT: begin
          if (nuse == CW'(2) || kcnt == nuse - CW'(1)) begin
            state <= S_FIN;
          end else begin
            kcnt  <= kcnt + CW'(1);
            state <= S_RDB;
          end
        end
        S_FIN: begin
          if (found) begin
            job   <= J_WD;
            state <= S_PAIR;
          end else begin
            tex   <= '0;
            state <= S_OUT;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_op <= sq_op - sq_t;
          end
          sq_res <= sq_res_next;
          sq_one <= sq_one >> 2;
          it     <= it - 6'd1;
          if (it == '0) begin
            // saturate at the top of the 31-bit field
            tex   <= (sq_res_next > 68'h7FFFFFFF) ? 31'h7FFFFFFF : sq_res_next[30:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.hit          <= found;
            result.hit_x        <= bx;
            result.hit_y        <= by;
            result.wall_start_x <= wsx;
            result.wall_start_y <= wsy;
            result.wall_end_x   <= wex;
            result.wall_end_y   <= wey;
            result.tex_offset   <= tex;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a cast beat always starts work
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.action) |=> (state != S_IDLE))
    else $error("cast beat did not start work");

  // a load beat finishes in its own cycle
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && !item.action) |=> (state == S_IDLE))
    else $error("load beat left the block busy");

  // a miss carries no offset and a zero wall start x and wall end y
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.hit) |-> (result.tex_offset == '0 && result.wall_start_x == '0
      && result.wall_end_y == '0))
    else $error("miss result with nonzero wall data");

endmodule
